[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock edge, skipped while reset is high.
`define ASSERT_IMPL(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Plain condition checked every clock edge.
`define ASSERT_ALWAYS(label, clk, cond, msg) \
   label: assert property (@(posedge clk) (cond)) else $error(msg);
`endif

[rtl/qet_pkg.sv]
// Package for the quadratic escape-time block: widths, register indexes,
// saturating Q6.26 helpers. No dependencies.
package qet_pkg;
   localparam int COORD_BITS = 12;
   localparam int ITER_BITS  = 10;
   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 26;
   localparam int ADDR_BITS  = 5;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [ITER_BITS-1:0]  iter_type;

   typedef enum logic [2:0] {
      REG_SCALE  = 3'd0,
      REG_ORG_RE = 3'd1,
      REG_ORG_IM = 3'd2,
      REG_SEED_RE = 3'd3,
      REG_SEED_IM = 3'd4,
      REG_LIMIT  = 3'd5,
      REG_MODE   = 3'd6,
      REG_RADIUS = 3'd7
   } reg_index_type;

   typedef struct packed {
      word_type zr;
      word_type zi;
      word_type cr;
      word_type ci;
      coord_type col;
      coord_type row;
   } job_type;

   localparam word_type WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   function automatic word_type sat_wide(input logic signed [WORD_BITS+1:0] v);
      if (v > $signed({{2{1'b0}}, WMAX})) return WMAX;
      if (v < $signed({{2{1'b1}}, WMIN})) return WMIN;
      return v[WORD_BITS-1:0];
   endfunction

   function automatic word_type sat_add(input word_type a, input word_type b);
      logic signed [WORD_BITS+1:0] s;
      s = {{2{a[WORD_BITS-1]}}, a} + {{2{b[WORD_BITS-1]}}, b};
      return sat_wide(s);
   endfunction

   function automatic word_type sat_sub(input word_type a, input word_type b);
      logic signed [WORD_BITS+1:0] s;
      s = {{2{a[WORD_BITS-1]}}, a} - {{2{b[WORD_BITS-1]}}, b};
      return sat_wide(s);
   endfunction

   // floor-rounded product shifted down, saturated
   function automatic word_type scale_prod(input logic signed [2*WORD_BITS-1:0] p);
      logic signed [2*WORD_BITS-1:0] q;
      q = p >>> FRAC_BITS;
      if (q > $signed({{WORD_BITS{1'b0}}, WMAX})) return WMAX;
      if (q < $signed({{WORD_BITS{1'b1}}, WMIN})) return WMIN;
      return q[WORD_BITS-1:0];
   endfunction
endpackage

[rtl/quadratic_escape_time.sv]
// Quadratic escape-time evaluator (Mandelbrot / Julia) with APB registers.
// Each pixel passes the front stages and the queue, is loaded in the idle state,
// then steps through the multiply, add and check states until escape or the limit.
// The engine takes a new pixel only after it has finished the last one;
// the front keeps accepting until the queue and the front stages are full.
// Synchronous active-high reset loads register defaults and empties all stages.
module quadratic_escape_time (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  qet_pkg::coord_type req_pixel_col,
   input  qet_pkg::coord_type req_pixel_row,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qet_pkg::iter_type rsp_escape_count,
   output logic              rsp_inside_set,
   output qet_pkg::coord_type rsp_out_col,
   output qet_pkg::coord_type rsp_out_row,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [qet_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import qet_pkg::*;

   logic [30:0] scale_ff, radius_ff;
   word_type    org_re_ff, org_im_ff, seed_re_ff, seed_im_ff;
   iter_type    limit_ff;
   logic        mode_ff;
   logic        wr;
   reg_index_type idx;
   logic        fj_valid, fj_ready, qj_valid, qj_ready;
   job_type     fj, qj;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign idx = reg_index_type'(csr_paddr[ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= 31'd335544;
         org_re_ff <= -32'sd167772160;
         org_im_ff <= -32'sd100663296;
         seed_re_ff <= '0;
         seed_im_ff <= '0;
         limit_ff <= iter_type'(100);
         mode_ff <= 1'b0;
         radius_ff <= 31'd268435456;
      end else if (wr) begin
         unique case (idx)
            REG_SCALE:   scale_ff <= csr_pwdata[30:0];
            REG_ORG_RE:  org_re_ff <= csr_pwdata;
            REG_ORG_IM:  org_im_ff <= csr_pwdata;
            REG_SEED_RE: seed_re_ff <= csr_pwdata;
            REG_SEED_IM: seed_im_ff <= csr_pwdata;
            REG_LIMIT:   limit_ff <= csr_pwdata[ITER_BITS-1:0];
            REG_MODE:    mode_ff <= csr_pwdata[0];
            REG_RADIUS:  radius_ff <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (idx)
         REG_SCALE:   csr_prdata = {1'b0, scale_ff};
         REG_ORG_RE:  csr_prdata = org_re_ff;
         REG_ORG_IM:  csr_prdata = org_im_ff;
         REG_SEED_RE: csr_prdata = seed_re_ff;
         REG_SEED_IM: csr_prdata = seed_im_ff;
         REG_LIMIT:   csr_prdata = {22'd0, limit_ff};
         REG_MODE:    csr_prdata = {31'd0, mode_ff};
         REG_RADIUS:  csr_prdata = {1'b0, radius_ff};
         default:     csr_prdata = '0;
      endcase
   end

   qet_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_pixel_col, .req_pixel_row,
      .scale(scale_ff), .org_re(org_re_ff), .org_im(org_im_ff),
      .seed_re(seed_re_ff), .seed_im(seed_im_ff), .mode(mode_ff),
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
   );

   qet_queue u_queue (
      .clock, .reset, .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
      .out_valid(qj_valid), .out_ready(qj_ready), .out_job(qj)
   );

   qet_engine u_engine (
      .clock, .reset, .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
      .limit(limit_ff), .radius(radius_ff), .rsp_valid, .rsp_ready,
      .rsp_escape_count, .rsp_inside_set, .rsp_out_col, .rsp_out_row
   );
endmodule

[rtl/qet_front.sv]
// Front end: maps a pixel to the complex plane and builds the start job.
// Depends on qet_pkg.
module qet_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  qet_pkg::coord_type req_pixel_col,
   input  qet_pkg::coord_type req_pixel_row,
   input  logic [30:0]       scale,
   input  qet_pkg::word_type org_re,
   input  qet_pkg::word_type org_im,
   input  qet_pkg::word_type seed_re,
   input  qet_pkg::word_type seed_im,
   input  logic              mode,
   output logic              job_valid,
   input  logic              job_ready,
   output qet_pkg::job_type  job
);
   import qet_pkg::*;

   logic      s1_valid_ff, s1_valid_in;
   coord_type s1_col_ff, s1_row_ff;
   logic signed [WORD_BITS+12:0] pr_ff, pi_ff;
   logic      s2_valid_ff, s2_valid_in;
   job_type   s2_job_ff, s2_job_in;
   logic      adv1, adv2;
   word_type  pr, pi;

   assign adv2 = !s2_valid_ff || job_ready;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_ready = adv1;
   assign s1_valid_in = adv1 ? req_valid : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      pr = (pr_ff > $signed({13'd0, WMAX})) ? WMAX : pr_ff[WORD_BITS-1:0];
      pi = (pi_ff > $signed({13'd0, WMAX})) ? WMAX : pi_ff[WORD_BITS-1:0];
      s2_job_in.col = s1_col_ff;
      s2_job_in.row = s1_row_ff;
      if (mode) begin
         s2_job_in.zr = sat_add(pr, org_re);
         s2_job_in.zi = sat_add(pi, org_im);
         s2_job_in.cr = seed_re;
         s2_job_in.ci = seed_im;
      end else begin
         s2_job_in.zr = '0;
         s2_job_in.zi = '0;
         s2_job_in.cr = sat_add(pr, org_re);
         s2_job_in.ci = sat_add(pi, org_im);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (adv1 && req_valid) begin
         s1_col_ff <= req_pixel_col;
         s1_row_ff <= req_pixel_row;
         pr_ff <= $signed({1'b0, req_pixel_col}) * $signed({1'b0, scale});
         pi_ff <= $signed({1'b0, req_pixel_row}) * $signed({1'b0, scale});
      end
      if (adv2 && s1_valid_ff) s2_job_ff <= s2_job_in;
   end

   assign job_valid = s2_valid_ff;
   assign job = s2_job_ff;
endmodule

[rtl/qet_queue.sv]
// Two-entry job queue between front end and iteration engine.
// Depends on qet_pkg.
module qet_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  qet_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output qet_pkg::job_type out_job
);
   import qet_pkg::*;

   job_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign wp_in = push ? !wp_ff : wp_ff;
   assign rp_in = pop ? !rp_ff : rp_ff;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   assign out_job = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_job;
   end
endmodule

[rtl/qet_engine.sv]
// Iteration engine: shared complex square-and-add, stepped through multiply, add and check states.
// Depends on qet_pkg.
module qet_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  qet_pkg::job_type  job,
   input  qet_pkg::iter_type limit,
   input  logic [30:0]       radius,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qet_pkg::iter_type rsp_escape_count,
   output logic              rsp_inside_set,
   output qet_pkg::coord_type rsp_out_col,
   output qet_pkg::coord_type rsp_out_row
);
   import qet_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_ADD  = 4'b0100,
      ST_CHK  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   job_type   cur_ff;
   iter_type  n_ff;
   word_type  rr_ff, ii_ff, ri_ff, mr_ff, mi_ff;
   logic      out_valid_ff;
   iter_type  out_cnt_ff;
   logic      out_in_ff;
   coord_type out_col_ff, out_row_ff;
   logic      finish, out_free;
   word_type  nzr, nzi, m;

   assign out_free = !out_valid_ff || rsp_ready;
   assign job_ready = state_ff == ST_IDLE;
   assign nzr = sat_add(sat_sub(rr_ff, ii_ff), cur_ff.cr);
   assign nzi = sat_add(sat_add(ri_ff, ri_ff), cur_ff.ci);
   assign m = sat_add(mr_ff, mi_ff);

   always_comb begin
      state_in = state_ff;
      finish = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (job_valid) state_in = ST_MUL;
         ST_MUL: begin
            if (n_ff >= limit) begin
               if (out_free) begin
                  finish = 1'b1;
                  state_in = ST_IDLE;
               end
            end else state_in = ST_ADD;
         end
         ST_ADD: state_in = ST_CHK;
         ST_CHK: begin
            if (!m[WORD_BITS-1] && {1'b0, m} >= {2'b0, radius}) begin
               if (out_free) begin
                  finish = 1'b1;
                  state_in = ST_IDLE;
               end
            end else state_in = ST_MUL;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            cur_ff <= job;
            n_ff <= iter_type'(1);
         end
         ST_MUL: begin
            rr_ff <= scale_prod(cur_ff.zr * cur_ff.zr);
            ii_ff <= scale_prod(cur_ff.zi * cur_ff.zi);
            ri_ff <= scale_prod(cur_ff.zr * cur_ff.zi);
         end
         ST_ADD: begin
            cur_ff.zr <= nzr;
            cur_ff.zi <= nzi;
         end
         ST_CHK: begin
            mr_ff <= mr_ff;
         end
         default: ;
      endcase
      if (state_ff == ST_ADD) begin
         mr_ff <= scale_prod(nzr * nzr);
         mi_ff <= scale_prod(nzi * nzi);
      end
      if (state_ff == ST_CHK && state_in == ST_MUL) n_ff <= n_ff + iter_type'(1);
      if (finish) begin
         out_cnt_ff <= n_ff;
         out_in_ff <= n_ff == limit;
         out_col_ff <= cur_ff.col;
         out_row_ff <= cur_ff.row;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_escape_count = out_cnt_ff;
   assign rsp_inside_set = out_in_ff;
   assign rsp_out_col = out_col_ff;
   assign rsp_out_row = out_row_ff;
endmodule

[rtl/qet_checker.sv]
// Port-level checker for the escape-time block, bound to the top level.
// Depends on qet_pkg and assert_macros.svh.
`include "assert_macros.svh"
module qet_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input qet_pkg::iter_type rsp_escape_count,
   input logic rsp_inside_set,
   input qet_pkg::coord_type rsp_out_col,
   input logic csr_pready
);
   import qet_pkg::*;

   `ASSERT_IMPL(a_rsp_hold, clock, reset,
      $past(rsp_valid && !rsp_ready) |-> rsp_valid, "result dropped while stalled")
   `ASSERT_IMPL(a_rsp_stable, clock, reset,
      $past(rsp_valid && !rsp_ready) |-> $stable(rsp_out_col), "result changed while stalled")
   `ASSERT_IMPL(a_count_nz, clock, reset,
      rsp_valid |-> rsp_escape_count != '0 || rsp_inside_set == 1'b0, "zero count flagged inside")
   `ASSERT_ALWAYS(a_pready, clock, csr_pready, "pready low")
endmodule

bind quadratic_escape_time qet_checker u_qet_checker (.*);

[verif/tb_quadratic_escape_time.sv]
// Self-checking testbench for quadratic_escape_time: random pixel stimulus with
// register phases, in-bench escape-time predictor. Depends on rtl/qet_pkg.sv.
module tb_quadratic_escape_time;
   import qet_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
   } pixel_type;

   typedef struct {
      logic [ITER_BITS-1:0]  count;
      logic                  in_set;
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
   } escape_type;

   localparam longint WORD_HI = 64'sd2147483647;
   localparam longint WORD_LO = -64'sd2147483648;
   localparam longint CYCLE_LIMIT = 64'd40_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [COORD_BITS-1:0] req_pixel_col = '0;
   logic [COORD_BITS-1:0] req_pixel_row = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [ITER_BITS-1:0] rsp_escape_count;
   logic rsp_inside_set;
   logic [COORD_BITS-1:0] rsp_out_col;
   logic [COORD_BITS-1:0] rsp_out_row;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   quadratic_escape_time u_dut (.*);

   // configuration shadow
   longint cfg_scale, cfg_org_re, cfg_org_im, cfg_seed_re, cfg_seed_im;
   longint cfg_limit, cfg_mode, cfg_radius;

   pixel_type pending_pixels[$];
   escape_type expected_escapes[$];
   int error_count = 0;
   int checked_count = 0;
   int inside_count = 0;
   longint cycle_count = 0;
   bit hold_rsp = 1'b0;
   bit gaps_on = 1'b1;

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic longint clamp_word(longint v);
      if (v > WORD_HI) return WORD_HI;
      if (v < WORD_LO) return WORD_LO;
      return v;
   endfunction

   // floor-rounded Q6.26 product; operands are word values so 64 bits suffice
   function automatic longint q_mul(longint a, longint b);
      longint p;
      p = a * b;
      return clamp_word(p >>> FRAC_BITS);
   endfunction

   function automatic escape_type escape_time(pixel_type px);
      escape_type r;
      longint pr, pi, zr, zi, cr, ci, rr, ii, ri, mag2, n;
      pr = clamp_word(clamp_word(longint'(px.col) * cfg_scale) + cfg_org_re);
      pi = clamp_word(clamp_word(longint'(px.row) * cfg_scale) + cfg_org_im);
      if (cfg_mode != 0) begin
         zr = pr; zi = pi; cr = cfg_seed_re; ci = cfg_seed_im;
      end else begin
         zr = 0; zi = 0; cr = pr; ci = pi;
      end
      n = 1;
      while (n < cfg_limit) begin
         rr = q_mul(zr, zr);
         ii = q_mul(zi, zi);
         ri = q_mul(zr, zi);
         zr = clamp_word(clamp_word(rr - ii) + cr);
         zi = clamp_word(clamp_word(ri + ri) + ci);
         mag2 = clamp_word(q_mul(zr, zr) + q_mul(zi, zi));
         if (mag2 >= cfg_radius) break;
         n++;
      end
      r.count = n[ITER_BITS-1:0];
      r.in_set = (n == cfg_limit);
      r.col = px.col;
      r.row = px.row;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
   endtask

   function automatic int random_gap();
      if (!gaps_on) return 0;
      if ($urandom_range(0, 99) < 60) return 0;
      if ($urandom_range(0, 99) < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // pixel driver
   int req_wait = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
      end else begin
         if (req_valid) begin
            expected_escapes.push_back(escape_time('{req_pixel_col, req_pixel_row}));
         end
         if (req_wait > 0) begin
            req_wait <= req_wait - 1;
            req_valid <= 1'b0;
         end else if (pending_pixels.size() > 0) begin
            req_pixel_col <= pending_pixels[0].col;
            req_pixel_row <= pending_pixels[0].row;
            void'(pending_pixels.pop_front());
            req_valid <= 1'b1;
            req_wait <= random_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor
   int rsp_wait = 0;
   always @(posedge clock) begin
      escape_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_escapes.size() == 0) begin
            report_mismatch("unexpected transaction col", rsp_out_col, -1);
         end else begin
            want = expected_escapes.pop_front();
            checked_count++;
            if (rsp_inside_set) inside_count++;
            if (rsp_escape_count !== want.count)
               report_mismatch("escape_count", rsp_escape_count, want.count);
            if (rsp_inside_set !== want.in_set)
               report_mismatch("inside_set", rsp_inside_set, want.in_set);
            if (rsp_out_col !== want.col) report_mismatch("out_col", rsp_out_col, want.col);
            if (rsp_out_row !== want.row) report_mismatch("out_row", rsp_out_row, want.row);
         end
      end
      if (reset || hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_valid && rsp_ready) rsp_wait <= random_gap();
      end
   end

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_BITS'(4 * int'(idx));
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_SCALE:   cfg_scale = longint'(value[30:0]);
         REG_ORG_RE:  cfg_org_re = longint'($signed(value));
         REG_ORG_IM:  cfg_org_im = longint'($signed(value));
         REG_SEED_RE: cfg_seed_re = longint'($signed(value));
         REG_SEED_IM: cfg_seed_im = longint'($signed(value));
         REG_LIMIT:   cfg_limit = longint'(value[ITER_BITS-1:0]);
         REG_MODE:    cfg_mode = longint'(value[0]);
         REG_RADIUS:  cfg_radius = longint'(value[30:0]);
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_pixels.size() > 0 || req_valid || expected_escapes.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic queue_pixel(int col, int row);
      pending_pixels.push_back('{COORD_BITS'(col), COORD_BITS'(row)});
   endtask

   task automatic set_view(logic [31:0] scale, logic [31:0] ore, logic [31:0] oim,
                           logic [31:0] sre, logic [31:0] sim, logic [31:0] lim,
                           logic [31:0] mode, logic [31:0] rad);
      write_reg(REG_SCALE, scale);
      write_reg(REG_ORG_RE, ore);
      write_reg(REG_ORG_IM, oim);
      write_reg(REG_SEED_RE, sre);
      write_reg(REG_SEED_IM, sim);
      write_reg(REG_LIMIT, lim);
      write_reg(REG_MODE, mode);
      write_reg(REG_RADIUS, rad);
   endtask

   task automatic random_batch(int count, int max_coord);
      repeat (count) queue_pixel($urandom_range(0, max_coord), $urandom_range(0, max_coord));
   endtask

   initial begin
      cfg_scale = 335544; cfg_org_re = -167772160; cfg_org_im = -100663296;
      cfg_seed_re = 0; cfg_seed_im = 0; cfg_limit = 100; cfg_mode = 0;
      cfg_radius = 268435456;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: extremes and a few interior points
      queue_pixel(0, 0);
      queue_pixel(4095, 4095);
      queue_pixel(4095, 0);
      queue_pixel(0, 4095);
      queue_pixel(300, 150);
      queue_pixel(2730, 1365);
      drain();

      // limit one and zero, scale zero, huge scale, saturating origins
      set_view(0, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 1, 0, 268435456);
      queue_pixel(0, 0); queue_pixel(4095, 4095);
      drain();
      write_reg(REG_LIMIT, 0);
      write_reg(REG_SCALE, 32'h7fff_ffff);
      queue_pixel(4095, 1); queue_pixel(0, 0);
      drain();
      // bailout zero, then the largest bailout, reached only by a saturated magnitude; no check on the start value
      set_view(335544, 32'hf600_0000, 32'hfa00_0000, 0, 0, 20, 1, 0);
      queue_pixel(0, 0); queue_pixel(700, 450);
      drain();
      set_view(1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1023, 1,
               32'h7fff_ffff);
      queue_pixel(4095, 4095); queue_pixel(0, 0);
      drain();

      // random phases: Mandelbrot and Julia views, mostly short limits
      for (int phase = 0; phase < 14; phase++) begin
         logic [31:0] lim;
         lim = (phase % 5 == 4) ? $urandom_range(200, 1023) : $urandom_range(1, 60);
         set_view($urandom_range(10000, 400000), $urandom_range(0, 1) ? -32'sd167772160
                                                                       : $urandom(),
                  -32'sd100663296 + $urandom_range(0, 67108864),
                  $urandom_range(0, 1) ? -32'sd53687091 + $urandom_range(0, 30000000)
                                       : $urandom(),
                  $urandom_range(0, 1) ? 32'sd10737418 : $urandom(),
                  lim, phase[0], (phase == 7) ? $urandom() : 268435456);
         gaps_on = (phase % 4 != 3);
         if (phase == 5) begin
            hold_rsp = 1'b1;
            random_batch(40, 511);
            repeat (3000) @(posedge clock);
            hold_rsp = 1'b0;
            random_batch(80, 511);
         end else begin
            random_batch(120, (phase % 3 == 0) ? 4095 : 511);
         end
         drain();
      end

      $display("covered %0d pixels in 19 register settings, %0d inside the set",
               checked_count, inside_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+rtl
rtl/qet_pkg.sv
rtl/qet_front.sv
rtl/qet_queue.sv
rtl/qet_engine.sv
rtl/quadratic_escape_time.sv
rtl/qet_checker.sv
verif/tb_quadratic_escape_time.sv
